### hw/rtl/skl_pkg.sv
package skl_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int KEY_W        = 32;
	localparam int OP_W         = 2;
	localparam int STATUS_W     = 2;
	localparam int COUNT_OUT_W  = 5;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

	// per-cycle command shared by every cell in the row
	typedef struct packed {
		logic compare;
		logic insert;
		logic remove;
	} cell_ctrl_t;

endpackage

### hw/rtl/skl_cell.sv
module skl_cell (
	input  logic                             clk,
	input  skl_pkg::cell_ctrl_t              ctrl,
	input  logic                             occupied,
	input  logic signed [skl_pkg::KEY_W-1:0] op_key,
	input  logic signed [skl_pkg::KEY_W-1:0] left_key,
	input  logic                             left_less,
	input  logic signed [skl_pkg::KEY_W-1:0] right_key,
	output logic signed [skl_pkg::KEY_W-1:0] cell_key,
	output logic                             less,
	output logic                             equal
);
	import skl_pkg::*;

	logic signed [KEY_W-1:0] key_q;
	logic                    less_q;
	logic                    equal_q;

	// compare first, then shift on the next cycle from the held flags
	always_ff @(posedge clk) begin
		if (ctrl.compare) begin
			less_q  <= occupied && (key_q < op_key);
			equal_q <= occupied && (key_q == op_key);
		end
		if (ctrl.insert && !less_q) begin
			key_q <= left_less ? op_key : left_key;
		end else if (ctrl.remove && !less_q) begin
			key_q <= right_key;
		end
	end

	assign cell_key = key_q;
	assign less     = less_q;
	assign equal    = equal_q;

endmodule

### hw/rtl/sorted_key_list_unit.sv
// Sorted key list: holds up to CAPACITY signed keys in ascending order in a row
// of cells, duplicates allowed. Pulse start with operation and key while busy is
// low; the beat is taken at that edge. Busy then stays high while every cell
// compares its key with the operand and while the row then shifts right for an
// insert or left for a remove; after that done is high for exactly one cycle with
// status, entry_count, is_empty, first_key and last_key describing the store
// after the operation. The receiver cannot stall: sample the result while done
// is high. A new beat may be started in the same cycle as done, so the block
// takes no new operation until the last one reaches done; the compare register
// in each cell followed by the shift sets that pace. entry_count carries the
// low five bits of the held count. After reset the store is empty.
module sorted_key_list_unit #(
	parameter int CAPACITY = skl_pkg::CAPACITY_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic [skl_pkg::OP_W-1:0]                operation,
	input  logic signed [skl_pkg::KEY_W-1:0]        key,
	output logic                                    done,
	output logic [skl_pkg::STATUS_W-1:0]            status,
	output logic [skl_pkg::COUNT_OUT_W-1:0]         entry_count,
	output logic                                    is_empty,
	output logic signed [skl_pkg::KEY_W-1:0]        first_key,
	output logic signed [skl_pkg::KEY_W-1:0]        last_key
);
	import skl_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_RES  = 2'd3;

	logic [1:0]              state_q;
	logic [OP_W-1:0]         op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CW-1:0]           count_q;
	logic [STATUS_W-1:0]     status_q;

	logic                    accept;
	logic                    found;
	cell_ctrl_t              ctrl;

	logic signed [KEY_W-1:0] cell_key [CAPACITY];
	logic [CAPACITY-1:0]     less_v;
	logic [CAPACITY-1:0]     equal_v;
	logic [CAPACITY-1:0]     occ_v;
	logic signed [KEY_W-1:0] last_acc;

	assign accept = start && !busy;
	assign busy   = (state_q == ST_CMP) || (state_q == ST_UPD);
	assign done   = (state_q == ST_RES);

	// keys are sorted, so equal entries sit together; any hit will do
	assign found = |equal_v;

	always_comb begin
		ctrl.compare = (state_q == ST_CMP);
		ctrl.insert  = (state_q == ST_UPD) && (op_q == OP_INSERT) && (count_q != CAP_C);
		ctrl.remove  = (state_q == ST_UPD) && (op_q == OP_REMOVE) && found;
	end

	// sequencer: take the beat, compare, shift, report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: state_q <= accept ? ST_CMP : ST_IDLE;
				ST_CMP:  state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_RES;
				ST_RES:  state_q <= accept ? ST_CMP : ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operand hold
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			key_q <= key;
		end
	end

	// count and status advance in the shift cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.insert) begin
			count_q <= count_q + CW'(1);
		end else if (ctrl.remove) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			unique case (op_q) inside
				OP_INSERT: status_q <= (count_q == CAP_C) ? STAT_FULL : STAT_OK;
				OP_REMOVE,
				OP_SEARCH: status_q <= found ? STAT_OK : STAT_ABSENT;
				default:   status_q <= STAT_OK;
			endcase
		end
	end

	// row of cells; the ends see themselves as neighbours
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [KEY_W-1:0] left_key;
		logic                    left_less;
		logic signed [KEY_W-1:0] right_key;

		assign occ_v[i] = (count_q > CW'(i));

		if (i == 0) begin : g_head
			assign left_key  = cell_key[i];
			assign left_less = 1'b1;
		end else begin : g_body
			assign left_key  = cell_key[i-1];
			assign left_less = less_v[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_key = cell_key[i];
		end else begin : g_next
			assign right_key = cell_key[i+1];
		end

		skl_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occupied  (occ_v[i]),
			.op_key    (key_q),
			.left_key  (left_key),
			.left_less (left_less),
			.right_key (right_key),
			.cell_key  (cell_key[i]),
			.less      (less_v[i]),
			.equal     (equal_v[i])
		);
	end

	// the last occupied cell is the one whose right neighbour is free
	always_comb begin
		last_acc = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (occ_v[i] && ((i == CAPACITY - 1) || !occ_v[(i + 1) % CAPACITY])) begin
				last_acc = last_acc | cell_key[i];
			end
		end
	end

	assign status      = status_q;
	assign entry_count = COUNT_OUT_W'(count_q);
	assign is_empty    = (count_q == '0);
	assign first_key   = is_empty ? '0 : cell_key[0];
	assign last_key    = last_acc;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_after_shift: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_UPD))
		else $error("result strobe without a shift cycle before it");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("held count beyond capacity");

	a_full_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STAT_FULL)) |-> (count_q == CAP_C))
		else $error("insert refused while store not full");

endmodule

### bench/sorted_key_list_unit_tb.sv
module sorted_key_list_unit_tb;

	import skl_pkg::*;

	localparam int CLK_PERIOD = 4;
	localparam int LIST_DEPTH = CAPACITY_DEF;
	localparam int RANDOM_OPS = 1250;
	localparam int DRAIN_CYCLES = 8;

	// the fourth operation code is unused by the block: it must leave the store alone
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [OP_W-1:0]         op;
		logic signed [KEY_W-1:0] k;
	} list_cmd_t;

	typedef struct {
		logic [STATUS_W-1:0]     status;
		logic [COUNT_OUT_W-1:0]  entry_count;
		logic                    is_empty;
		logic signed [KEY_W-1:0] first_key;
		logic signed [KEY_W-1:0] last_key;
	} list_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic [OP_W-1:0]               operation = OP_INSERT;
	logic signed [KEY_W-1:0]       key = '0;
	logic                          busy;
	logic                          done;
	logic [STATUS_W-1:0]           status;
	logic [COUNT_OUT_W-1:0]        entry_count;
	logic                          is_empty;
	logic signed [KEY_W-1:0]       first_key;
	logic signed [KEY_W-1:0]       last_key;

	// commands waiting to be offered, and results owed by the block, oldest first
	list_cmd_t    cmd_queue[$];
	list_result_t awaited_results[$];

	// shadow copy of the store: ascending keys in slots below shadow_count
	logic signed [KEY_W-1:0] shadow_keys [LIST_DEPTH];
	int                      shadow_count = 0;

	int fail_count = 0;
	int idle_left = 0;
	int burst_left = 0;

	sorted_key_list_unit #(
		.CAPACITY(LIST_DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.key        (key),
		.done       (done),
		.status     (status),
		.entry_count(entry_count),
		.is_empty   (is_empty),
		.first_key  (first_key),
		.last_key   (last_key)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Slot of the first held key equal to k, or -1 when it is not held.
	function automatic int shadow_find(logic signed [KEY_W-1:0] k);
		int hit;
		hit = -1;
		for (int i = 0; i < shadow_count; i++)
			if (hit < 0 && shadow_keys[i] == k)
				hit = i;
		return hit;
	endfunction

	// Apply one operation to the shadow store and return what the block must report.
	function automatic list_result_t shadow_apply(logic [OP_W-1:0] op,
			logic signed [KEY_W-1:0] k);
		list_result_t r;
		int pos;
		r.status = STAT_OK;
		case (op)
			OP_INSERT: begin
				if (shadow_count >= LIST_DEPTH) begin
					// full: refuse and leave the store as it is
					r.status = STAT_FULL;
				end else begin
					// place after every smaller key, shifting the tail up one slot
					pos = 0;
					while (pos < shadow_count && shadow_keys[pos] < k)
						pos++;
					for (int i = shadow_count; i > pos; i--)
						shadow_keys[i] = shadow_keys[i - 1];
					shadow_keys[pos] = k;
					shadow_count++;
				end
			end
			OP_REMOVE: begin
				pos = shadow_find(k);
				if (pos < 0) begin
					r.status = STAT_ABSENT;
				end else begin
					// close the gap left by the first equal key
					for (int i = pos; i + 1 < shadow_count; i++)
						shadow_keys[i] = shadow_keys[i + 1];
					shadow_count--;
				end
			end
			OP_SEARCH: begin
				if (shadow_find(k) < 0)
					r.status = STAT_ABSENT;
			end
			default: begin
				// unused code: report the store unchanged
			end
		endcase
		r.entry_count = COUNT_OUT_W'(shadow_count);
		r.is_empty    = (shadow_count == 0);
		r.first_key   = (shadow_count == 0) ? '0 : shadow_keys[0];
		r.last_key    = (shadow_count == 0) ? '0 : shadow_keys[shadow_count - 1];
		return r;
	endfunction

	// Idle cycles before the next beat: mostly none or a few, now and then a long
	// pause, with occasional bursts that run back to back.
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 9);
		return $urandom_range(10, 40);
	endfunction

	// Keys mostly from a narrow band so that duplicates, hits and misses are common;
	// the rest are the extremes, the key just above the minimum and full-width random patterns.
	function automatic logic signed [KEY_W-1:0] pick_key();
		int s;
		s = $urandom_range(0, 15);
		if (s < 9)
			return $signed(KEY_W'($urandom_range(0, 8))) - 4;
		if (s == 9)
			return {1'b1, {(KEY_W - 1){1'b0}}};
		if (s == 10)
			return {1'b0, {(KEY_W - 1){1'b1}}};
		if (s == 11)
			return {1'b1, {(KEY_W - 2){1'b0}}, 1'b1};
		return $urandom;
	endfunction

	task automatic push_cmd(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] k);
		list_cmd_t c;
		c.op = op;
		c.k  = k;
		cmd_queue.push_back(c);
	endtask

	task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
		if (got !== want) begin
			$display("%0t %s: expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Driver: a beat is taken at an edge where start is high and busy is low.
	// Predict the result for each beat as it goes in, then either offer the next
	// command straight away or drop start for a gap.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				awaited_results.push_back(shadow_apply(operation, key));
				idle_left = pick_gap();
			end
			// hold the offered beat while the block is busy; otherwise the line is free
			if (!start || !busy) begin
				if (idle_left == 0 && cmd_queue.size() > 0) begin
					operation <= cmd_queue[0].op;
					key       <= cmd_queue[0].k;
					start     <= 1'b1;
					void'(cmd_queue.pop_front());
				end else begin
					if (idle_left > 0)
						idle_left--;
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: the block cannot be held off, so take every result on the edge that
	// closes its done cycle and compare it against the oldest prediction.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				$display("%0t unexpected result: status %0d entry_count %0d",
					$time, status, entry_count);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				check_field("status", want.status, status);
				check_field("entry_count", want.entry_count, entry_count);
				check_field("is_empty", want.is_empty, is_empty);
				check_field("first_key", want.first_key, first_key);
				check_field("last_key", want.last_key, last_key);
			end
		end
	end

	initial begin
		int n;
		int block_len;
		int insert_weight;
		int r;
		logic [OP_W-1:0] op;

		// directed: operations on the empty store, extremes, duplicates, misses
		push_cmd(OP_UNUSED, 32'sd7);
		push_cmd(OP_SEARCH, 32'sd0);
		push_cmd(OP_REMOVE, 32'sd0);
		push_cmd(OP_INSERT, {1'b0, {(KEY_W - 1){1'b1}}});
		push_cmd(OP_INSERT, {1'b1, {(KEY_W - 1){1'b0}}});
		push_cmd(OP_INSERT, 32'sd0);
		push_cmd(OP_INSERT, -32'sd1);
		push_cmd(OP_INSERT, 32'sd0);
		push_cmd(OP_SEARCH, {1'b1, {(KEY_W - 1){1'b0}}});
		push_cmd(OP_SEARCH, 32'sd1);
		push_cmd(OP_REMOVE, 32'sd0);
		push_cmd(OP_REMOVE, 32'sd5);
		push_cmd(OP_UNUSED, -32'sd1);
		push_cmd(OP_REMOVE, {1'b0, {(KEY_W - 1){1'b1}}});
		push_cmd(OP_REMOVE, {1'b1, {(KEY_W - 1){1'b0}}});
		push_cmd(OP_SEARCH, 32'sd0);

		// random: blocks that lean towards filling, draining or neither, so the
		// store swings between empty and full and refused inserts appear
		n = 0;
		while (n < RANDOM_OPS) begin
			r = $urandom_range(0, 2);
			insert_weight = (r == 0) ? 15 : (r == 1) ? 50 : 85;
			block_len = $urandom_range(20, 80);
			for (int j = 0; j < block_len && n < RANDOM_OPS; j++) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					op = OP_UNUSED;
				else if (r < insert_weight)
					op = OP_INSERT;
				else if (r < insert_weight + (100 - insert_weight) / 2)
					op = OP_REMOVE;
				else
					op = OP_SEARCH;
				push_cmd(op, pick_key());
				n++;
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// advance until every command is in and every result is back, then let the
		// pipeline drain to catch any stray strobe
		@(negedge clk);
		while (cmd_queue.size() != 0 || start || awaited_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
